>>> sv/assert_macros.svh
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Whenever the trigger holds, the property must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
		else $error("assertion failed");

// Whenever the trigger holds, the property must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
		else $error("assertion failed");

`endif

>>> sv/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] CRC_SEED    = 8'h00;
	localparam logic [7:0] CRC_TOPBIT  = 8'h80;
	localparam logic [4:0] FRAME_OVERHEAD = 5'd5;

	// One queued request: a whole header group or one payload byte, with the
	// closing CRC byte attached when the frame ends here.
	typedef struct packed {
		logic       is_start;
		logic       has_end;
		logic [7:0] source_id;
		logic [7:0] type_len;
		logic [7:0] data_byte;
		logic [7:0] crc;
		logic [4:0] frame_length;
	} cmd_t;

	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOPBIT) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Running CRC after the two sync bytes, which never change.
	localparam logic [7:0] CRC_SYNC = crc_fold(crc_fold(CRC_SEED, SYNC_FIRST), SYNC_SECOND);

endpackage

`default_nettype wire

>>> sv/sfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_front #(
	parameter int unsigned MAX_PAYLOAD = 15
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic          func,
	input  wire logic [7:0]    source_id,
	input  wire logic [3:0]    data_type,
	input  wire logic [3:0]    payload_length,
	input  wire logic [7:0]    data_byte,
	input  wire logic          q_full,
	output logic               cmd_valid,
	output sfp_pkg::cmd_t      cmd
);
	import sfp_pkg::*;

	localparam logic FUNC_START = 1'b0;
	localparam logic [3:0] MAX_LEN = 4'(MAX_PAYLOAD);

	logic       in_frame_q;
	logic [3:0] remaining_q;
	logic [7:0] crc_q;
	logic [4:0] total_q;

	logic       accept;
	logic       is_start;
	logic [3:0] plen_sat;
	logic [7:0] type_len;
	logic [7:0] start_crc;
	logic [7:0] pay_crc;
	logic [4:0] start_total;
	logic       pay_last;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign is_start = (func == FUNC_START);

	always_comb begin
		plen_sat    = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
		type_len    = {data_type, plen_sat};
		start_crc   = crc_fold(crc_fold(CRC_SYNC, source_id), type_len);
		start_total = FRAME_OVERHEAD + {1'b0, plen_sat};
		pay_crc     = crc_fold(crc_q, data_byte);
		pay_last    = (remaining_q == 4'd1);
	end

	// A payload byte outside a frame produces no request at all.
	assign cmd_valid = accept && (is_start || in_frame_q);

	always_comb begin
		cmd.is_start  = is_start;
		cmd.source_id = source_id;
		cmd.type_len  = type_len;
		cmd.data_byte = data_byte;
		if (is_start) begin
			cmd.has_end      = (plen_sat == 4'd0);
			cmd.crc          = start_crc;
			cmd.frame_length = start_total;
		end else begin
			cmd.has_end      = pay_last;
			cmd.crc          = pay_crc;
			cmd.frame_length = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			remaining_q <= 4'd0;
			crc_q       <= CRC_SEED;
			total_q     <= 5'd0;
		end else if (accept) begin
			if (is_start) begin
				in_frame_q  <= (plen_sat != 4'd0);
				remaining_q <= plen_sat;
				crc_q       <= start_crc;
				total_q     <= start_total;
			end else if (in_frame_q) begin
				crc_q       <= pay_crc;
				remaining_q <= remaining_q - 4'd1;
				if (pay_last) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/sfp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire sfp_pkg::cmd_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output sfp_pkg::cmd_t      rd_data,
	output logic               rd_valid
);
	import sfp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = slots_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/sfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire sfp_pkg::cmd_t head,
	output logic               head_pop,
	output logic [7:0]         out_byte,
	output logic               frame_end,
	output logic [4:0]         frame_length,
	output logic               empty,
	input  wire logic          pop
);
	import sfp_pkg::*;

	localparam logic [2:0] POS_SYNC_FIRST  = 3'd0;
	localparam logic [2:0] POS_SYNC_SECOND = 3'd1;
	localparam logic [2:0] POS_SENSOR      = 3'd2;
	localparam logic [2:0] POS_TYPE_LEN    = 3'd3;
	localparam logic [2:0] POS_HDR_CRC     = 3'd4;
	localparam logic [2:0] POS_DATA        = 3'd0;
	localparam logic [2:0] POS_DATA_CRC    = 3'd1;

	logic [2:0] idx_q;
	logic       ovalid_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic [4:0] len_q;

	logic [2:0] last_idx;
	logic       at_last;
	logic       load;
	logic [7:0] sel_byte;
	logic       sel_end;

	always_comb begin
		if (head.is_start) begin
			last_idx = head.has_end ? POS_HDR_CRC : POS_TYPE_LEN;
		end else begin
			last_idx = head.has_end ? POS_DATA_CRC : POS_DATA;
		end
		at_last = (idx_q == last_idx);
	end

	always_comb begin
		sel_byte = head.crc;
		sel_end  = 1'b1;
		if (head.is_start) begin
			unique case (idx_q)
				POS_SYNC_FIRST: begin
					sel_byte = SYNC_FIRST;
					sel_end  = 1'b0;
				end
				POS_SYNC_SECOND: begin
					sel_byte = SYNC_SECOND;
					sel_end  = 1'b0;
				end
				POS_SENSOR: begin
					sel_byte = head.source_id;
					sel_end  = 1'b0;
				end
				POS_TYPE_LEN: begin
					sel_byte = head.type_len;
					sel_end  = 1'b0;
				end
				default: begin
					sel_byte = head.crc;
					sel_end  = 1'b1;
				end
			endcase
		end else if (idx_q == POS_DATA) begin
			sel_byte = head.data_byte;
			sel_end  = 1'b0;
		end
	end

	// The output register refills from the queue head whenever one is waiting and the register is free or being taken.
	assign load     = head_valid && (!ovalid_q || pop);
	assign head_pop = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 3'd0;
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
			idx_q    <= at_last ? 3'd0 : idx_q + 3'd1;
		end else if (pop) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			end_q  <= sel_end;
			len_q  <= sel_end ? head.frame_length : 5'd0;
		end
	end

	assign empty        = !ovalid_q;
	assign out_byte     = byte_q;
	assign frame_end    = end_q;
	assign frame_length = len_q;

endmodule

`default_nettype wire

>>> sv/sensor_frame_packer_crc8_core.sv
// Channel   Handshake           Payload
// input     push / full         func, source_id, data_type, payload_length, data_byte
// result    empty / pop         out_byte, frame_end, frame_length
//
// One input item is taken per cycle while the request queue has room.
// Results leave at one byte per cycle from the output register while pop is held:
// a start item gives four or five bytes, a payload byte one or two, so the result
// port sets the sustained rate. The first byte of an item passes through the queue
// and then the output register. arst_n clears the frame state, the queue and the
// output register. Either side may stall; the queue absorbs the difference.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_packer_crc8_core #(
	parameter int unsigned MAX_PAYLOAD = 15,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       func,
	input  wire logic [7:0] source_id,
	input  wire logic [3:0] data_type,
	input  wire logic [3:0] payload_length,
	input  wire logic [7:0] data_byte,
	output logic [7:0]      out_byte,
	output logic            frame_end,
	output logic [4:0]      frame_length,
	output logic            empty,
	input  wire logic       pop
);
	import sfp_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic q_full;
	cmd_t head;
	logic head_valid;
	logic head_pop;

	sfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.func          (func),
		.source_id     (source_id),
		.data_type     (data_type),
		.payload_length(payload_length),
		.data_byte     (data_byte),
		.q_full        (q_full),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd)
	);

	sfp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.full    (q_full),
		.rd_en   (head_pop),
		.rd_data (head),
		.rd_valid(head_valid)
	);

	sfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (head_pop),
		.out_byte    (out_byte),
		.frame_end   (frame_end),
		.frame_length(frame_length),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

`default_nettype wire

>>> sv/sfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic [7:0] out_byte,
	input wire logic       frame_end,
	input wire logic [4:0] frame_length,
	input wire logic       empty,
	input wire logic       pop
);
	import sfp_pkg::*;

	// Only the closing byte carries a length, and that length is a real frame size.
	`ASSERT_IMPLY(a_len_only_on_end, clk, arst_n, !empty && !frame_end, frame_length == 5'd0)
	`ASSERT_IMPLY(a_len_range, clk, arst_n, !empty && frame_end, (frame_length >= FRAME_OVERHEAD) && (frame_length <= 5'd20))
	// A result that is not taken stays as it is.
	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(frame_end))
	// Whatever follows the close of a frame is the first sync byte of the next one.
	`ASSERT_NEXT(a_sync_after_end, clk, arst_n, !empty && pop && frame_end, empty || (out_byte == SYNC_FIRST))

endmodule

bind sensor_frame_packer_crc8_core sfp_checker u_sfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_byte    (out_byte),
	.frame_end   (frame_end),
	.frame_length(frame_length),
	.empty       (empty),
	.pop         (pop)
);

`default_nettype wire

>>> test/tb_sensor_frame_packer_crc8_core.sv
`timescale 1ns / 1ps

module tb_sensor_frame_packer_crc8_core;

	localparam logic       FUNC_START     = 1'b0;
	localparam logic       FUNC_PAYLOAD   = 1'b1;
	localparam logic [7:0] SYNC_A         = 8'hAA;
	localparam logic [7:0] SYNC_B         = 8'h55;
	localparam logic [7:0] CRC_GEN        = 8'h07;
	localparam logic [7:0] CRC8_SEED      = 8'h00;
	localparam logic [4:0] FRAME_OVERHEAD = 5'd5;
	localparam int         MAX_PAYLOAD    = 15;
	localparam int         CYCLE_LIMIT    = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       is_end;
		logic [4:0] len;
	} frame_byte_t;

	class frame_scoreboard;
		logic [7:0]  crc;
		logic [3:0]  remaining;
		bit          framing;
		logic [4:0]  total;
		frame_byte_t awaited[$];
		int          errors;

		function new();
			crc = CRC8_SEED;
			remaining = '0;
			framing = 1'b0;
			total = '0;
			errors = 0;
		endfunction

		function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
			logic [7:0] r;
			r = c ^ b;
			repeat (8) begin
				r = r[7] ? ({r[6:0], 1'b0} ^ CRC_GEN) : {r[6:0], 1'b0};
			end
			return r;
		endfunction

		function void emit(logic [7:0] b);
			awaited.push_back('{data: b, is_end: 1'b0, len: 5'd0});
			crc = crc8_next(crc, b);
		endfunction

		function void close_frame();
			awaited.push_back('{data: crc, is_end: 1'b1, len: total});
			framing = 1'b0;
		endfunction

		// Works out the bytes that one accepted request adds to the frame stream.
		function void note_request(logic f, logic [7:0] sid, logic [3:0] dt,
				logic [3:0] plen, logic [7:0] db);
			logic [3:0] n;
			if (f == FUNC_START) begin
				n = (int'(plen) > MAX_PAYLOAD) ? 4'(MAX_PAYLOAD) : plen;
				crc = CRC8_SEED;
				emit(SYNC_A);
				emit(SYNC_B);
				emit(sid);
				emit({dt, n});
				total = FRAME_OVERHEAD + 5'(n);
				remaining = n;
				if (n == 4'd0) begin
					close_frame();
				end else begin
					framing = 1'b1;
				end
			end else if (framing) begin
				emit(db);
				remaining = remaining - 4'd1;
				if (remaining == 4'd0) begin
					close_frame();
				end
			end
		endfunction

		function void check_result(logic [7:0] b, logic e, logic [4:0] len);
			frame_byte_t want;
			if (awaited.size() == 0) begin
				$error("byte 0x%02h arrived with nothing awaited", b);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (b !== want.data) begin
				$error("out_byte: expected 0x%02h, got 0x%02h", want.data, b);
				errors++;
			end
			if (e !== want.is_end) begin
				$error("frame_end: expected %0d, got %0d", want.is_end, e);
				errors++;
			end
			if (len !== want.len) begin
				$error("frame_length: expected %0d, got %0d", want.len, len);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic       func;
	logic [7:0] source_id;
	logic [3:0] data_type;
	logic [3:0] payload_length;
	logic [7:0] data_byte;
	logic [7:0] out_byte;
	logic       frame_end;
	logic [4:0] frame_length;
	logic       empty;
	logic       pop;

	frame_scoreboard sb = new();
	int burst_left;
	int cycle_count;

	sensor_frame_packer_crc8_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.source_id      (source_id),
		.data_type      (data_type),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.out_byte       (out_byte),
		.frame_end      (frame_end),
		.frame_length   (frame_length),
		.empty          (empty),
		.pop            (pop)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offers one request and holds it until the block takes it. Bursts of
	// requests are separated by idle gaps of random length.
	task automatic offer(input logic f, input logic [7:0] sid, input logic [3:0] dt,
			input logic [3:0] plen, input logic [7:0] db);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
		end
		push           <= 1'b1;
		func           <= f;
		source_id      <= sid;
		data_type      <= dt;
		payload_length <= plen;
		data_byte      <= db;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_request(f, sid, dt, plen, db);
		burst_left--;
	endtask

	task automatic send_start(input logic [7:0] sid, input logic [3:0] dt,
			input logic [3:0] plen);
		offer(FUNC_START, sid, dt, plen, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_payload(input logic [7:0] db);
		offer(FUNC_PAYLOAD, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)), db);
	endtask

	initial begin
		int  sent;
		int  plen;
		int  cut;
		int  n;
		bit  drained;
		bit  tail_open;
		arst_n         = 1'b0;
		push           = 1'b0;
		func           = FUNC_START;
		source_id      = '0;
		data_type      = '0;
		payload_length = '0;
		data_byte      = '0;
		burst_left     = 0;
		sent           = 0;
		drained        = 1'b0;
		tail_open      = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A payload byte with no frame open must vanish.
		send_payload(8'h3C);
		send_start(8'h00, 4'h0, 4'd0);
		send_start(8'hFF, 4'hF, 4'd0);
		send_start(8'h01, 4'h1, 4'd1);
		send_payload(8'h00);
		send_start(8'h5A, 4'hA, 4'd2);
		send_payload(8'hFF);
		send_payload(8'h80);
		// This frame is cut short by the next start and gets no CRC byte.
		send_start(8'h80, 4'h7, 4'd3);
		send_payload(8'h01);
		send_start(8'hA5, 4'h5, 4'd0);
		send_payload(8'h7E);
		send_start(8'h3C, 4'h8, 4'd15);
		send_payload(8'hAA);
		send_payload(8'h55);
		send_payload(8'hFE);
		send_start(8'hC3, 4'h3, 4'd1);
		send_payload(8'h7F);

		// Mostly complete frames with random content, with some cut short and
		// some stray payload bytes between them.
		while (sent < 320) begin
			if ($urandom_range(0, 9) == 0) begin
				send_payload(8'($urandom_range(0, 255)));
				if (tail_open) begin
					sent++;
				end
				continue;
			end
			plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
			cut = plen;
			if (plen > 0 && $urandom_range(0, 6) == 0) begin
				cut = $urandom_range(0, plen - 1);
			end
			send_start(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 4'(plen));
			sent++;
			for (n = 0; n < cut; n++) begin
				send_payload(8'($urandom_range(0, 255)));
				sent++;
			end
			tail_open = (cut < plen);
			if (!drained && sent >= 200) begin
				drained = 1'b1;
				push <= 1'b0;
				burst_left = 0;
				while (sb.pending() != 0) @(posedge clk);
			end
		end

		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// The receiver changes its stall pattern now and then, and once holds off
	// for a long stretch so that the block fills up and refuses requests.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int seen;
		bit held;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		seen      = 0;
		held      = 1'b0;
		pop       = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(out_byte, frame_end, frame_length);
				seen++;
			end
			if (!held && seen >= 100) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: begin
						pop <= 1'b1;
					end
					1: begin
						pop <= 1'($urandom_range(0, 1));
					end
					2: begin
						pop <= ($urandom_range(0, 4) == 0);
					end
					default: begin
						pop <= ((mode_left % 8) < 6);
					end
				endcase
			end
		end
	end

endmodule

>>> sim.f
+incdir+sv
sv/sfp_pkg.sv
sv/sfp_front.sv
sv/sfp_fifo.sv
sv/sfp_back.sv
sv/sensor_frame_packer_crc8_core.sv
sv/sfp_checker.sv
test/tb_sensor_frame_packer_crc8_core.sv
